### sv/wclm_pkg.sv
// ----------------------------------------------------------------------------
// wclm_pkg
// Shared types, grid constants and letter masks for the word clock decoder.
// ----------------------------------------------------------------------------
package wclm_pkg;

    localparam int GRID_WIDTH = 11;
    localparam int GRID_ROWS  = 11;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SEG_W    = 4;
    localparam int SEL_W    = 12;
    localparam int DOTS_W   = 4;
    localparam int HOURS    = 12;

    // last segment, taken for every minute past the end of the hour
    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(11);

    typedef logic [GRID_ROWS-1:0][GRID_WIDTH-1:0] t_rows;

    typedef enum logic [3:0] {
        W_ES, W_IST, W_UM, W_FUNF, W_ZEHN, W_ZWANZIG, W_VIERTEL, W_DREIVIERTEL,
        W_NACH, W_VOR, W_HALB, W_UHR, W_NONE
    } t_word;

    typedef struct packed {
        logic  pre_um;
        t_word w0;
        t_word w1;
        t_word w2;
        logic  next_hour;
        logic  with_uhr;
    } t_phrase;

    localparam logic [DOTS_W-1:0] DOTS_NONE  = 4'b0000;
    localparam logic [DOTS_W-1:0] DOTS_ONE   = 4'b1000;
    localparam logic [DOTS_W-1:0] DOTS_TWO   = 4'b1100;
    localparam logic [DOTS_W-1:0] DOTS_THREE = 4'b1110;
    localparam logic [DOTS_W-1:0] DOTS_FOUR  = 4'b1111;

    // a run of letters on one row
    function automatic t_rows letters(input int row, input int lsb, input int len);
        t_rows r;
        r = '0;
        for (int c = 0; c < GRID_WIDTH; c++) begin
            if (c >= lsb && c < lsb + len) begin
                r[row][c] = 1'b1;
            end
        end
        return r;
    endfunction

    // every minute word has one place it can land, whatever came before it
    function automatic t_rows word_rows(input t_word w);
        t_rows r;
        r = '0;
        unique case (w)
            W_ES:          r = letters(0, 0, 2);
            W_IST:         r = letters(0, 3, 3);
            W_UM:          r = letters(3, 0, 2);
            W_FUNF:        r = letters(0, 7, 4);
            W_ZEHN:        r = letters(2, 7, 4);
            W_ZWANZIG:     r = letters(2, 0, 7);
            W_VIERTEL:     r = letters(1, 4, 7);
            W_DREIVIERTEL: r = letters(1, 0, 11);
            W_NACH:        r = letters(4, 7, 4);
            W_VOR:         r = letters(4, 0, 3);
            W_HALB:        r = letters(5, 0, 4);
            W_UHR:         r = letters(10, 8, 3);
            default:       r = '0;
        endcase
        return r;
    endfunction

    // hour words all sit past the last minute word
    function automatic t_rows hour_rows(input logic [SEG_W-1:0] h, input logic short_one);
        t_rows r;
        r = '0;
        unique case (h)
            4'd0:    r = letters(9, 6, 5);
            4'd1:    r = short_one ? letters(6, 0, 3) : letters(6, 0, 4);
            4'd2:    r = letters(6, 4, 4);
            4'd3:    r = letters(7, 0, 4);
            4'd4:    r = letters(7, 7, 4);
            4'd5:    r = letters(5, 7, 4);
            4'd6:    r = letters(8, 0, 5);
            4'd7:    r = letters(9, 0, 6);
            4'd8:    r = letters(8, 7, 4);
            4'd9:    r = letters(10, 3, 4);
            4'd10:   r = letters(10, 0, 4);
            4'd11:   r = letters(5, 5, 3);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### sv/word_clock_letter_mask_top.sv
// ----------------------------------------------------------------------------
// word_clock_letter_mask_top
// German word clock decoder: hour and minute in, lit letters per grid row
// and four minute dots out.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+----------------------------------
//  input    | i_in_valid   | o_in_stall   | i_hour, i_minute
//  output   | o_out_valid  | i_out_stall  | o_row0_mask..o_row10_mask,
//           |              |              | o_minute_dots
//  config   | i_cfg_we     | none         | i_cfg_data (phrasing select)
//
//  one transaction per cycle while the output does not stall; the input register
//  feeds the result register, with the phrase decode and mask build in between
//  synchronous active-low reset empties both stages and clears the select
//  a stall on the output holds the result; the input register still takes
//  a transaction while it is empty or the result register can move on
// ----------------------------------------------------------------------------
module word_clock_letter_mask_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wclm_pkg::SEL_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [wclm_pkg::HOUR_W-1:0]       i_hour,
    input  logic [wclm_pkg::MINUTE_W-1:0]     i_minute,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [wclm_pkg::GRID_WIDTH-1:0]   o_row0_mask,
    output logic [wclm_pkg::GRID_WIDTH-1:0]   o_row1_mask,
    output logic [wclm_pkg::GRID_WIDTH-1:0]   o_row2_mask,
    output logic [wclm_pkg::GRID_WIDTH-1:0]   o_row3_mask,
    output logic [wclm_pkg::GRID_WIDTH-1:0]   o_row4_mask,
    output logic [wclm_pkg::GRID_WIDTH-1:0]   o_row5_mask,
    output logic [wclm_pkg::GRID_WIDTH-1:0]   o_row6_mask,
    output logic [wclm_pkg::GRID_WIDTH-1:0]   o_row7_mask,
    output logic [wclm_pkg::GRID_WIDTH-1:0]   o_row8_mask,
    output logic [wclm_pkg::GRID_WIDTH-1:0]   o_row9_mask,
    output logic [wclm_pkg::GRID_WIDTH-1:0]   o_row10_mask,
    output logic [wclm_pkg::DOTS_W-1:0]       o_minute_dots
);
    import wclm_pkg::*;

    logic [SEL_W-1:0]    r_phrasing_select;
    logic                r_s1_valid;
    logic [HOUR_W-1:0]   r_hour;
    logic [MINUTE_W-1:0] r_minute;
    logic                r_out_valid;
    t_rows               r_rows;
    logic [DOTS_W-1:0]   r_dots;

    t_phrase             phrase;
    t_rows               n_rows;
    logic [DOTS_W-1:0]   n_dots;
    logic                adv_out;
    logic                in_take;

    assign adv_out    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !adv_out;
    assign in_take    = i_in_valid && !o_in_stall;

    wclm_phrase u_phrase (
        .i_minute          (r_minute),
        .i_phrasing_select (r_phrasing_select),
        .o_phrase          (phrase),
        .o_minute_dots     (n_dots)
    );

    wclm_render u_render (
        .i_phrase (phrase),
        .i_hour   (r_hour),
        .o_rows   (n_rows)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phrasing_select <= '0;
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_phrasing_select <= i_cfg_data;
            end
            if (!r_s1_valid || adv_out) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_hour   <= i_hour;
            r_minute <= i_minute;
        end
        if (adv_out && r_s1_valid) begin
            r_rows <= n_rows;
            r_dots <= n_dots;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row0_mask   = r_rows[0];
    assign o_row1_mask   = r_rows[1];
    assign o_row2_mask   = r_rows[2];
    assign o_row3_mask   = r_rows[3];
    assign o_row4_mask   = r_rows[4];
    assign o_row5_mask   = r_rows[5];
    assign o_row6_mask   = r_rows[6];
    assign o_row7_mask   = r_rows[7];
    assign o_row8_mask   = r_rows[8];
    assign o_row9_mask   = r_rows[9];
    assign o_row10_mask  = r_rows[10];
    assign o_minute_dots = r_dots;

    // a stall toward the source only while the input register is full
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with an empty input register");

    // an accepted transaction is held in the input register next cycle
    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_s1_valid)
        else $error("accepted transaction was lost");

    // every sentence starts with es ist
    a_es_ist_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_row0_mask[1:0] == 2'b11 && o_row0_mask[5:3] == 3'b111))
        else $error("es ist not lit");

    // dots fill from the top bit
    a_dots_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_minute_dots == DOTS_NONE || o_minute_dots == DOTS_ONE
                         || o_minute_dots == DOTS_TWO || o_minute_dots == DOTS_THREE
                         || o_minute_dots == DOTS_FOUR))
        else $error("minute dots out of pattern");

endmodule

### sv/wclm_phrase.sv
// ----------------------------------------------------------------------------
// wclm_phrase
// Picks the five-minute segment, its phrase and the minute dots.
// ----------------------------------------------------------------------------
module wclm_phrase (
    input  logic [wclm_pkg::MINUTE_W-1:0] i_minute,
    input  logic [wclm_pkg::SEL_W-1:0]    i_phrasing_select,
    output wclm_pkg::t_phrase             o_phrase,
    output logic [wclm_pkg::DOTS_W-1:0]   o_minute_dots
);
    import wclm_pkg::*;

    logic [SEG_W-1:0]    seg;
    logic [MINUTE_W-1:0] seg_base;
    logic [MINUTE_W-1:0] rem_full;
    logic [2:0]          rem;
    logic                alt;

    // segment by threshold compares, saturating at the last one
    always_comb begin
        seg = '0;
        for (int k = 1; k <= 11; k++) begin
            if (i_minute >= MINUTE_W'(5 * k)) begin
                seg = SEG_W'(k);
            end
        end
    end

    assign seg_base = {seg, 2'b00} + {2'b00, seg};
    assign rem_full = (i_minute >= MINUTE_W'(60)) ? i_minute - MINUTE_W'(60)
                                                  : i_minute - seg_base;
    assign rem      = rem_full[2:0];
    assign alt      = i_phrasing_select[seg];

    always_comb begin
        unique case (rem)
            3'd0:    o_minute_dots = DOTS_NONE;
            3'd1:    o_minute_dots = DOTS_ONE;
            3'd2:    o_minute_dots = DOTS_TWO;
            3'd3:    o_minute_dots = DOTS_THREE;
            3'd4:    o_minute_dots = DOTS_FOUR;
            default: o_minute_dots = DOTS_NONE;
        endcase
    end

    always_comb begin
        o_phrase = '{pre_um: 1'b0, w0: W_NONE, w1: W_NONE, w2: W_NONE,
                     next_hour: 1'b0, with_uhr: 1'b0};
        unique case (seg)
            4'd0: begin
                if (alt) o_phrase.pre_um = 1'b1;
                else     o_phrase.with_uhr = 1'b1;
            end
            4'd1: begin
                o_phrase.w0 = W_FUNF;
                o_phrase.w1 = W_NACH;
            end
            4'd2: begin
                o_phrase.w0 = W_ZEHN;
                o_phrase.w1 = W_NACH;
            end
            4'd3: begin
                o_phrase.w0 = W_VIERTEL;
                if (alt) o_phrase.next_hour = 1'b1;
                else     o_phrase.w1 = W_NACH;
            end
            4'd4: begin
                if (alt) begin
                    o_phrase.w0 = W_ZWANZIG;
                    o_phrase.w1 = W_NACH;
                end else begin
                    o_phrase.w0 = W_ZEHN;
                    o_phrase.w1 = W_VOR;
                    o_phrase.w2 = W_HALB;
                    o_phrase.next_hour = 1'b1;
                end
            end
            4'd5: begin
                o_phrase.w0 = W_FUNF;
                o_phrase.w1 = W_VOR;
                o_phrase.w2 = W_HALB;
                o_phrase.next_hour = 1'b1;
            end
            4'd6: begin
                o_phrase.w0 = W_HALB;
                o_phrase.next_hour = 1'b1;
            end
            4'd7: begin
                o_phrase.w0 = W_FUNF;
                o_phrase.w1 = W_NACH;
                o_phrase.w2 = W_HALB;
                o_phrase.next_hour = 1'b1;
            end
            4'd8: begin
                o_phrase.next_hour = 1'b1;
                if (alt) begin
                    o_phrase.w0 = W_ZWANZIG;
                    o_phrase.w1 = W_VOR;
                end else begin
                    o_phrase.w0 = W_ZEHN;
                    o_phrase.w1 = W_NACH;
                    o_phrase.w2 = W_HALB;
                end
            end
            4'd9: begin
                o_phrase.next_hour = 1'b1;
                if (alt) begin
                    o_phrase.w0 = W_DREIVIERTEL;
                end else begin
                    o_phrase.w0 = W_VIERTEL;
                    o_phrase.w1 = W_VOR;
                end
            end
            4'd10: begin
                o_phrase.w0 = W_ZEHN;
                o_phrase.w1 = W_VOR;
                o_phrase.next_hour = 1'b1;
            end
            default: begin
                o_phrase.w0 = W_FUNF;
                o_phrase.w1 = W_VOR;
                o_phrase.next_hour = 1'b1;
            end
        endcase
    end

endmodule

### sv/wclm_render.sv
// ----------------------------------------------------------------------------
// wclm_render
// Lights the words of a phrase and its hour on the letter grid.
// ----------------------------------------------------------------------------
module wclm_render (
    input  wclm_pkg::t_phrase           i_phrase,
    input  logic [wclm_pkg::HOUR_W-1:0] i_hour,
    output wclm_pkg::t_rows             o_rows
);
    import wclm_pkg::*;

    logic [HOUR_W-1:0] hour_mod;
    logic [SEG_W-1:0]  hour_adj;
    logic [SEG_W-1:0]  hour_name;

    // hour below 32, so one subtraction of 24 or 12 brings it under 12
    always_comb begin
        priority if (i_hour >= HOUR_W'(2 * HOURS)) begin
            hour_mod = i_hour - HOUR_W'(2 * HOURS);
        end else if (i_hour >= HOUR_W'(HOURS)) begin
            hour_mod = i_hour - HOUR_W'(HOURS);
        end else begin
            hour_mod = i_hour;
        end
    end

    assign hour_adj  = hour_mod[SEG_W-1:0] + SEG_W'(i_phrase.next_hour);
    assign hour_name = (hour_adj == SEG_W'(HOURS)) ? '0 : hour_adj;

    assign o_rows = word_rows(W_ES)
                  | word_rows(W_IST)
                  | (i_phrase.pre_um ? word_rows(W_UM) : '0)
                  | word_rows(i_phrase.w0)
                  | word_rows(i_phrase.w1)
                  | word_rows(i_phrase.w2)
                  | hour_rows(hour_name, i_phrase.with_uhr)
                  | (i_phrase.with_uhr ? word_rows(W_UHR) : '0);

endmodule
